// ===== design/tcsx_pkg.sv =====
`default_nettype none
package tcsx_pkg;
  localparam logic [1:0] ST_NEED = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FOUND = 2'd2;

  localparam logic [4:0] PH_TYPE = 5'd0;
  localparam logic [4:0] PH_VMAJ = 5'd1;
  localparam logic [4:0] PH_VMIN = 5'd2;
  localparam logic [4:0] PH_RLHI = 5'd3;
  localparam logic [4:0] PH_RLLO = 5'd4;
  localparam logic [4:0] PH_HTYPE = 5'd5;
  localparam logic [4:0] PH_HL0 = 5'd6;
  localparam logic [4:0] PH_HL1 = 5'd7;
  localparam logic [4:0] PH_HL2 = 5'd8;
  localparam logic [4:0] PH_RAND = 5'd9;
  localparam logic [4:0] PH_SIDL = 5'd10;
  localparam logic [4:0] PH_SID = 5'd11;
  localparam logic [4:0] PH_CSHI = 5'd12;
  localparam logic [4:0] PH_CSLO = 5'd13;
  localparam logic [4:0] PH_CS = 5'd14;
  localparam logic [4:0] PH_CML = 5'd15;
  localparam logic [4:0] PH_CM = 5'd16;
  localparam logic [4:0] PH_EXHI = 5'd17;
  localparam logic [4:0] PH_EXLO = 5'd18;
  localparam logic [4:0] PH_ETHI = 5'd19;
  localparam logic [4:0] PH_ETLO = 5'd20;
  localparam logic [4:0] PH_ELHI = 5'd21;
  localparam logic [4:0] PH_ELLO = 5'd22;
  localparam logic [4:0] PH_EXSKIP = 5'd23;
  localparam logic [4:0] PH_LSHI = 5'd24;
  localparam logic [4:0] PH_LSLO = 5'd25;
  localparam logic [4:0] PH_NT = 5'd26;
  localparam logic [4:0] PH_NLHI = 5'd27;
  localparam logic [4:0] PH_NLLO = 5'd28;
  localparam logic [4:0] PH_NSKIP = 5'd29;
  localparam logic [4:0] PH_HOST = 5'd30;
  localparam logic [4:0] PH_DONE = 5'd31;

  typedef struct packed {
    logic [7:0] data;
    logic first;
    logic last;
  } word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [16:0] offset;
    logic [15:0] length;
  } result_t;
endpackage
`default_nettype wire

// ===== design/tcsx_front.sv =====
`default_nettype none
module tcsx_front #(
  parameter int DEPTH = 4
) (
  input wire clk,
  input wire rst,
  input wire in_valid,
  output logic in_ready,
  input wire [7:0] data_byte,
  input wire first_byte,
  input wire last_byte,
  output logic q_valid,
  input wire q_ready,
  output tcsx_pkg::word_t q_word
);
  import tcsx_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  word_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;
  logic push, pop;

  assign in_ready = (count != AW'(0) + (AW+1)'(DEPTH)) || q_ready;
  assign push = in_valid && in_ready;
  assign q_valid = count != '0;
  assign pop = q_valid && q_ready;
  assign q_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: data_byte, first: first_byte, last: last_byte};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== design/tcsx_back.sv =====
`default_nettype none
module tcsx_back (
  input wire clk,
  input wire rst,
  input wire [16:0] max_window,
  input wire q_valid,
  output logic q_ready,
  input wire tcsx_pkg::word_t q_word,
  output logic out_valid,
  input wire out_ready,
  output tcsx_pkg::result_t out_res
);
  import tcsx_pkg::*;
  logic [16:0] bytes_seen, record_end_pos, ch_end_pos, ext_end, nl_end, host_start;
  logic [4:0] phase;
  logic [15:0] skip_rem, ext_kind, blank_len, dot_len, colon_pos;
  logic [23:0] fa;
  logic [7:0] entry_kind;
  logic [1:0] colon_count, held;
  logic port_nd, bracket, prev_blank, reported;

  logic [16:0] bytes_seen_next, record_end_pos_next, ch_end_pos_next, ext_end_next;
  logic [16:0] nl_end_next, host_start_next;
  logic [4:0] phase_next;
  logic [15:0] skip_rem_next, ext_kind_next, blank_len_next, dot_len_next, colon_pos_next;
  logic [23:0] fa_next;
  logic [7:0] entry_kind_next;
  logic [1:0] colon_count_next, held_next;
  logic port_nd_next, bracket_next, prev_blank_next, reported_next;
  logic emit;
  result_t res_next;

  logic [7:0] b;
  logic [16:0] pos, c, n;
  logic [15:0] v16, hl, sk;
  logic [23:0] v;
  logic [17:0] r_hello, r_ext, r_nl;
  logic herr, report, blank, fin, doskip;
  logic [1:0] st;
  logic [4:0] fin_ph;
  logic [16:0] len_sel;

  assign q_ready = !out_valid || out_ready;

  function automatic logic [17:0] room(input logic [16:0] e, input logic [16:0] cc);
    room = (e > cc) ? {1'b0, e - cc} : 18'd0;
  endfunction

  always_comb begin
    bytes_seen_next = bytes_seen; record_end_pos_next = record_end_pos;
    ch_end_pos_next = ch_end_pos; ext_end_next = ext_end; nl_end_next = nl_end;
    host_start_next = host_start; phase_next = phase; skip_rem_next = skip_rem;
    ext_kind_next = ext_kind; blank_len_next = blank_len; dot_len_next = dot_len;
    colon_pos_next = colon_pos; fa_next = fa; entry_kind_next = entry_kind;
    colon_count_next = colon_count; held_next = held; port_nd_next = port_nd;
    bracket_next = bracket; prev_blank_next = prev_blank; reported_next = reported;
    emit = 1'b0; res_next = '0; herr = 1'b0; report = 1'b0; st = ST_NEED;
    fin = 1'b0; fin_ph = PH_RAND; doskip = 1'b0; sk = '0;
    blank = 1'b0; len_sel = '0;
    b = q_word.data;
    if (q_word.first) begin
      bytes_seen_next = '0; record_end_pos_next = '0; ch_end_pos_next = '0;
      ext_end_next = '0; nl_end_next = '0; host_start_next = '0; phase_next = PH_TYPE;
      skip_rem_next = '0; ext_kind_next = '0; blank_len_next = '0; dot_len_next = '0;
      colon_pos_next = '0; fa_next = '0; entry_kind_next = '0; colon_count_next = '0;
      held_next = ST_NEED; port_nd_next = 1'b0; bracket_next = 1'b0;
      prev_blank_next = 1'b0; reported_next = 1'b0;
    end
    pos = bytes_seen_next;
    c = pos + 17'd1;
    n = c;
    v = {fa_next[15:0], b};
    v16 = v[15:0];
    hl = 16'(pos - host_start_next);
    r_hello = room(ch_end_pos_next, c);
    r_ext = room(ext_end_next, c);
    r_nl = room(nl_end_next, c);
    if (q_valid && q_ready && !reported_next) begin
      bytes_seen_next = n;
      case (phase_next)
        PH_TYPE: if (b != 8'h16) herr = 1'b1; else phase_next = PH_VMAJ;
        PH_VMAJ: if (b != 8'h03) herr = 1'b1; else phase_next = PH_VMIN;
        PH_VMIN: if (b > 8'h03) herr = 1'b1; else phase_next = PH_RLHI;
        PH_RLHI: begin fa_next = {16'd0, b}; phase_next = PH_RLLO; end
        PH_RLLO: begin
          if (v16 < 16'd4) herr = 1'b1;
          else begin
            record_end_pos_next = {1'b0, v16} + 17'd5;
            phase_next = PH_HTYPE;
          end
        end
        PH_HTYPE: if (b != 8'h01) begin held_next = ST_MISSING; phase_next = PH_DONE; end
                  else phase_next = PH_HL0;
        PH_HL0: begin fa_next = {16'd0, b}; phase_next = PH_HL1; end
        PH_HL1: begin fa_next = v; phase_next = PH_HL2; end
        PH_HL2: begin
          if (v < 24'd35 || ({7'd0, v} + 31'd4 > {14'd0, record_end_pos_next} - 31'd5)) begin
            held_next = ST_MISSING; phase_next = PH_DONE;
          end else begin
            ch_end_pos_next = 17'(v + 24'd9);
            skip_rem_next = 16'd34;
            phase_next = PH_RAND;
          end
        end
        PH_SIDL, PH_CML: begin
          if (r_hello < {10'd0, b} + 18'd2) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin
            doskip = 1'b1; sk = {8'd0, b};
            fin_ph = (phase_next == PH_SIDL) ? PH_SID : PH_CM;
          end
        end
        PH_CSHI, PH_EXHI, PH_ETHI, PH_ELHI, PH_LSHI, PH_NLHI: begin
          fa_next = {16'd0, b}; phase_next = phase_next + 5'd1;
        end
        PH_CSLO: begin
          if (r_hello < {2'd0, v16} + 18'd1) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin doskip = 1'b1; sk = v16; fin_ph = PH_CS; end
        end
        PH_EXLO: begin
          if (r_hello < {2'd0, v16}) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin
            ext_end_next = c + {1'b0, v16};
            if (room(c + {1'b0, v16}, c) < 18'd4) begin
              held_next = ST_MISSING; phase_next = PH_DONE;
            end else phase_next = PH_ETHI;
          end
        end
        PH_ETLO: begin ext_kind_next = v16; phase_next = PH_ELHI; end
        PH_ELLO: begin
          if (r_ext < {2'd0, v16}) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else if (ext_kind_next != 16'h0000) begin
            doskip = 1'b1; sk = v16; fin_ph = PH_EXSKIP;
          end else if (v16 < 16'd2) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin skip_rem_next = v16; phase_next = PH_LSHI; end
        end
        PH_LSLO: begin
          if (v16 > skip_rem_next - 16'd2) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin
            nl_end_next = c + {1'b0, v16};
            if (room(c + {1'b0, v16}, c) < 18'd3) begin
              held_next = ST_MISSING; phase_next = PH_DONE;
            end else phase_next = PH_NT;
          end
        end
        PH_NT: begin entry_kind_next = b; phase_next = PH_NLHI; end
        PH_NLLO: begin
          if (r_nl < {2'd0, v16}) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else if (entry_kind_next != 8'h00) begin
            doskip = 1'b1; sk = v16; fin_ph = PH_NSKIP;
          end else if (v16 == 16'd0) begin held_next = ST_MISSING; phase_next = PH_DONE; end
          else begin
            host_start_next = c; skip_rem_next = v16; fa_next = '0; phase_next = PH_HOST;
          end
        end
        PH_HOST: begin
          blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D);
          if (hl == 16'd0) bracket_next = (b == 8'h5B);
          if (blank) prev_blank_next = 1'b1;
          else begin
            blank_len_next = hl + 16'd1;
            if (b == 8'h3A) begin
              if (colon_count_next == 2'd0) begin
                colon_pos_next = hl;
                fa_next = {8'd0, prev_blank_next ? hl : dot_len_next};
                colon_count_next = 2'd1;
              end else colon_count_next = 2'd2;
            end else if (colon_count_next == 2'd1) begin
              if (prev_blank_next || b < 8'h30 || b > 8'h39) port_nd_next = 1'b1;
            end
            if (b != 8'h2E) dot_len_next = hl + 16'd1;
            else if (prev_blank_next) dot_len_next = hl;
            prev_blank_next = 1'b0;
          end
          skip_rem_next = skip_rem_next - 16'd1;
          if (skip_rem_next == 16'd0) begin
            if (bracket_next) len_sel = {1'b0, blank_len_next};
            else if (colon_count_next == 2'd1 && colon_pos_next != 16'd0 &&
                     {1'b0, blank_len_next} > {1'b0, colon_pos_next} + 17'd1 && !port_nd_next)
              len_sel = {1'b0, fa_next[15:0]};
            else len_sel = {1'b0, dot_len_next};
            if (len_sel == 17'd0) held_next = ST_MISSING;
            else begin dot_len_next = len_sel[15:0]; held_next = ST_FOUND; end
            phase_next = PH_DONE;
          end
        end
        PH_RAND, PH_SID, PH_CS, PH_CM, PH_EXSKIP, PH_NSKIP: begin
          skip_rem_next = skip_rem_next - 16'd1;
          if (skip_rem_next == 16'd0) begin fin = 1'b1; fin_ph = phase_next; end
        end
        default: ;
      endcase
      if (doskip) begin
        if (sk == 16'd0) fin = 1'b1;
        else begin skip_rem_next = sk; phase_next = fin_ph; end
      end
      if (fin) begin
        case (fin_ph)
          PH_RAND: phase_next = PH_SIDL;
          PH_SID: phase_next = PH_CSHI;
          PH_CS: phase_next = PH_CML;
          PH_CM: phase_next = PH_EXHI;
          PH_EXSKIP: if (r_ext < 18'd4) begin held_next = ST_MISSING; phase_next = PH_DONE; end
                     else phase_next = PH_ETHI;
          default: if (r_nl < 18'd3) begin held_next = ST_MISSING; phase_next = PH_DONE; end
                   else phase_next = PH_NT;
        endcase
      end
      if (herr) begin st = ST_MISSING; report = 1'b1; end
      else if (record_end_pos_next != '0) begin
        if (n >= record_end_pos_next) begin
          st = (held_next == ST_NEED) ? ST_MISSING : held_next; report = 1'b1;
        end else if (n >= max_window) begin st = ST_MISSING; report = 1'b1; end
      end
      if (report) reported_next = 1'b1;
      emit = report || q_word.last;
      res_next.status = st;
      res_next.offset = (st == ST_FOUND) ? host_start_next : '0;
      res_next.length = (st == ST_FOUND) ? dot_len_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res <= res_next;
    if (rst) begin
      out_valid <= 1'b0; phase <= PH_TYPE; reported <= 1'b0; held <= ST_NEED;
      bytes_seen <= '0; record_end_pos <= '0; ch_end_pos <= '0; ext_end <= '0;
      nl_end <= '0; host_start <= '0; skip_rem <= '0; ext_kind <= '0; blank_len <= '0;
      dot_len <= '0; colon_pos <= '0; fa <= '0; entry_kind <= '0; colon_count <= '0;
      port_nd <= 1'b0; bracket <= 1'b0; prev_blank <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        bytes_seen <= bytes_seen_next; record_end_pos <= record_end_pos_next;
        ch_end_pos <= ch_end_pos_next; ext_end <= ext_end_next; nl_end <= nl_end_next;
        host_start <= host_start_next; skip_rem <= skip_rem_next; ext_kind <= ext_kind_next;
        blank_len <= blank_len_next; dot_len <= dot_len_next; colon_pos <= colon_pos_next;
        fa <= fa_next; entry_kind <= entry_kind_next; colon_count <= colon_count_next;
        port_nd <= port_nd_next; bracket <= bracket_next; prev_blank <= prev_blank_next;
        held <= held_next; phase <= phase_next; reported <= reported_next;
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== design/tls_client_hello_sni_extractor.sv =====
`default_nettype none
// Parses one TLS ClientHello per TCP payload, one byte a cycle, and reports the trimmed
// SNI host offset and length. Bytes go into a short queue of QUEUE_DEPTH words; the
// parser behind it takes one word a cycle while its output register can be loaded,
// so the sustained rate is one byte per cycle. A result is loaded into the output
// register at the edge at which its byte leaves the queue, so with an empty queue it
// is offered once the byte has passed the queue memory and then the output register.
// While a result waits, the parser stops and the queue fills; the input stalls once
// it holds QUEUE_DEPTH words. max_window resets to 16384 and is written through cfg_we.
module tls_client_hello_sni_extractor #(
  parameter int QUEUE_DEPTH = 4
) (
  input wire clk,
  input wire rst,
  input wire cfg_we,
  input wire [16:0] cfg_wdata,
  input wire in_valid,
  output logic in_ready,
  input wire [7:0] data_byte,
  input wire first_byte,
  input wire last_byte,
  output logic out_valid,
  input wire out_ready,
  output logic [1:0] status,
  output logic [16:0] host_offset,
  output logic [15:0] host_length
);
  import tcsx_pkg::*;
  logic [16:0] max_window;
  logic q_valid, q_ready;
  word_t q_word;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) max_window <= 17'd16384;
    else if (cfg_we) max_window <= cfg_wdata;
  end

  tcsx_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .first_byte, .last_byte,
    .q_valid, .q_ready, .q_word
  );

  tcsx_back u_back (
    .clk, .rst, .max_window, .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .out_res(res)
  );

  assign status = res.status;
  assign host_offset = res.offset;
  assign host_length = res.length;
endmodule
`default_nettype wire
